// File: rtl/usps_pkg.sv
// shared types and constants for the udp port shard steering block
`default_nettype none
package usps_pkg;

    // word kinds on the input stream
    typedef enum logic
    {
        OP_BYTE  = 1'b0,
        OP_TABLE = 1'b1
    } opcode_t;

    // shard table word selectors
    localparam logic [4:0] WORD_VALID  = 5'd0;
    localparam logic [4:0] WORD_KEY    = 5'd1;
    localparam logic [4:0] WORD_COUNT  = 5'd2;
    localparam logic [4:0] WORD_OFFSET = 5'd3;
    localparam logic [4:0] WORD_PORT0  = 5'd4;
    localparam logic [4:0] WORD_LAST   = 5'd18;

    // frame layout
    localparam logic [7:0]  POS_ETYPE_HI = 8'd12;
    localparam logic [7:0]  POS_ETYPE_LO = 8'd13;
    localparam logic [7:0]  POS_PROTO    = 8'd23;
    localparam logic [7:0]  POS_DPORT_HI = 8'd36;
    localparam logic [7:0]  POS_DPORT_LO = 8'd37;
    localparam logic [8:0]  LEN_ETH      = 9'd14;
    localparam logic [8:0]  LEN_IP       = 9'd34;
    localparam logic [8:0]  MSG_START    = 9'd42;
    localparam logic [9:0]  MSG_BYTES    = 10'd4;
    localparam logic [7:0]  MAX_OFFSET   = 8'd64;
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    // fnv-1a 64; prime is 2^40 + 0x1b3
    localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
    localparam int          FNV_PRIME_SH = 40;

    // shard count width (count never above 15)
    localparam int CNT_W = 4;

    // job handed from front to back
    typedef struct packed
    {
        logic             do_mod;
        logic             verdict;
        logic [63:0]      hash;
        logic [CNT_W-1:0] cnt;
    } job_t;

endpackage
`default_nettype wire

// File: rtl/usps_fifo.sv
// two-entry queue between the front and back parts
`default_nettype none
module usps_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    // handshakes
    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_data;
    end

endmodule
`default_nettype wire

// File: rtl/usps_front.sv
// front part: parses frame bytes, hashes the message, holds the shard table
`default_nettype none
module usps_front #(
    parameter int MAX_SHARDS  = 8,
    parameter int TABLE_SLOTS = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire usps_pkg::opcode_t     in_op,
    input  wire logic                  in_last,
    input  wire logic [7:0]            in_byte,
    input  wire logic [1:0]            in_slot,
    input  wire logic [4:0]            in_word,
    input  wire logic [15:0]           in_value,
    output logic                       job_valid,
    input  wire logic                  job_ready,
    output usps_pkg::job_t             job,
    output logic [MAX_SHARDS-1:0][15:0] job_ports
);
    import usps_pkg::*;

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int KW = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;

    // shard table
    logic                        valid_reg  [TABLE_SLOTS];
    logic [15:0]                 key_reg    [TABLE_SLOTS];
    logic [7:0]                  count_reg  [TABLE_SLOTS];
    logic [7:0]                  offset_reg [TABLE_SLOTS];
    logic [MAX_SHARDS-1:0][15:0] ports_reg  [TABLE_SLOTS];

    // per-frame state
    logic [7:0]  pos_reg;
    logic [15:0] etype_reg, etype_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] dport_reg, dport_next;
    logic [2:0]  match_reg, match_next;
    logic [63:0] hash_reg, hash_next;

    logic        fire, byte_fire, tab_fire, in_msg;
    logic [SW-1:0] sidx;
    logic [7:0]  cnt8, off8;
    logic [8:0]  len, first;
    logic [9:0]  msg_end;
    logic [63:0] hx;
    logic [4:0]  k;

    assign in_ready  = job_ready;
    assign fire      = in_valid && in_ready;
    assign byte_fire = fire && (in_op == OP_BYTE);
    assign tab_fire  = fire && (in_op == OP_TABLE);
    assign job_valid = byte_fire && in_last;
    assign k         = in_word - WORD_PORT0;

    // header field capture and slot match
    always_comb
    begin
        etype_next = etype_reg;
        proto_next = proto_reg;
        dport_next = dport_reg;
        match_next = match_reg;
        if (pos_reg == POS_ETYPE_HI)
            etype_next = {in_byte, etype_reg[7:0]};
        if (pos_reg == POS_ETYPE_LO)
            etype_next = {etype_reg[15:8], in_byte};
        if (pos_reg == POS_PROTO)
            proto_next = in_byte;
        if (pos_reg == POS_DPORT_HI)
            dport_next = {in_byte, dport_reg[7:0]};
        if (pos_reg == POS_DPORT_LO)
        begin
            dport_next = {dport_reg[15:8], in_byte};
            match_next = 3'd0;
            for (int s = TABLE_SLOTS - 1; s >= 0; s--)
            begin
                if (valid_reg[s] && key_reg[s] == dport_next)
                    match_next = 3'(s + 1);
            end
        end
    end

    // live slot fields of the matched slot
    assign sidx    = SW'(match_next - 3'd1);
    assign cnt8    = count_reg[sidx];
    assign off8    = offset_reg[sidx];
    assign first   = MSG_START + {1'b0, off8};
    assign msg_end = {1'b0, first} + MSG_BYTES;
    assign len     = {1'b0, pos_reg} + 9'd1;
    assign in_msg  = (match_next != 3'd0) && ({1'b0, pos_reg} >= first)
                     && ({2'b00, pos_reg} < msg_end);

    // fnv-1a step: (h ^ b) * (2^40 + 0x1b3)
    assign hx = hash_reg ^ {56'd0, in_byte};
    always_comb
    begin
        hash_next = hash_reg;
        if (in_msg)
            hash_next = (hx << FNV_PRIME_SH) + 64'(hx * {55'd0, FNV_PRIME_LO});
    end

    // verdict of a frame at its last byte
    always_comb
    begin
        job.do_mod  = 1'b0;
        job.verdict = 1'b0;
        job.hash    = hash_next;
        job.cnt     = cnt8[CNT_W-1:0];
        job_ports   = ports_reg[sidx];
        priority if (len < LEN_ETH)
            job.verdict = 1'b1;
        else if (etype_next != ETYPE_IPV4)
            job.verdict = 1'b0;
        else if (len < LEN_IP)
            job.verdict = 1'b1;
        else if (proto_next != PROTO_UDP)
            job.verdict = 1'b0;
        else if (len < MSG_START)
            job.verdict = 1'b1;
        else if (match_next == 3'd0)
            job.verdict = 1'b0;
        else if (cnt8 == 8'd0 || cnt8 > 8'(MAX_SHARDS))
            job.verdict = 1'b0;
        else if (off8 > MAX_OFFSET)
            job.verdict = 1'b1;
        else if ({1'b0, len} < msg_end)
            job.verdict = 1'b1;
        else
            job.do_mod = 1'b1;
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 8'd0;
            etype_reg <= 16'd0;
            proto_reg <= 8'd0;
            dport_reg <= 16'd0;
            match_reg <= 3'd0;
            hash_reg  <= FNV_BASIS;
        end
        else if (byte_fire)
        begin
            if (in_last)
            begin
                pos_reg   <= 8'd0;
                etype_reg <= 16'd0;
                proto_reg <= 8'd0;
                dport_reg <= 16'd0;
                match_reg <= 3'd0;
                hash_reg  <= FNV_BASIS;
            end
            else
            begin
                pos_reg   <= (pos_reg == 8'd255) ? pos_reg : pos_reg + 8'd1;
                etype_reg <= etype_next;
                proto_reg <= proto_next;
                dport_reg <= dport_next;
                match_reg <= match_next;
                hash_reg  <= hash_next;
            end
        end
    end

    // table writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TABLE_SLOTS; s++)
            begin
                valid_reg[s]  <= 1'b0;
                key_reg[s]    <= 16'd0;
                count_reg[s]  <= 8'd0;
                offset_reg[s] <= 8'd0;
                ports_reg[s]  <= '0;
            end
        end
        else if (tab_fire && {1'b0, in_slot} < 3'(TABLE_SLOTS))
        begin
            if (in_word == WORD_VALID)
                valid_reg[in_slot[SW-1:0]] <= in_value[0];
            else if (in_word == WORD_KEY)
                key_reg[in_slot[SW-1:0]] <= in_value;
            else if (in_word == WORD_COUNT)
                count_reg[in_slot[SW-1:0]] <= in_value[7:0];
            else if (in_word == WORD_OFFSET)
                offset_reg[in_slot[SW-1:0]] <= in_value[7:0];
            else if (in_word <= WORD_LAST && k < 5'(MAX_SHARDS))
                ports_reg[in_slot[SW-1:0]][k[KW-1:0]] <= in_value;
        end
    end

endmodule
`default_nettype wire

// File: rtl/usps_back.sv
// back part: hash modulo shard count, port pick, output register
`default_nettype none
module usps_back #(
    parameter int MAX_SHARDS = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       job_valid,
    output logic                            job_ready,
    input  wire usps_pkg::job_t             job,
    input  wire logic [MAX_SHARDS-1:0][15:0] job_ports,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            verdict,
    output logic                            rewritten,
    output logic [15:0]                     new_port
);
    import usps_pkg::*;

    localparam int KW = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_MOD  = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [3:0]                  iter_reg, iter_next;
    logic [63:0]                 hash_reg, hash_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            rem_reg, rem_next;
    logic [MAX_SHARDS-1:0][15:0] ports_reg;
    logic                        verdict_reg, verdict_next;
    logic                        rew_reg, rew_next;
    logic [15:0]                 port_reg, port_next;
    logic [CNT_W-1:0]            step_rem;
    logic [63:0]                 step_hash;

    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_HOLD);
    assign verdict   = verdict_reg;
    assign rewritten = rew_reg;
    assign new_port  = port_reg;

    // four restoring remainder steps, top hash bits first
    always_comb
    begin
        logic [CNT_W:0] t;
        step_rem  = rem_reg;
        step_hash = hash_reg;
        for (int i = 0; i < 4; i++)
        begin
            t         = {step_rem, step_hash[63]};
            step_hash = {step_hash[62:0], 1'b0};
            if (t >= {1'b0, cnt_reg})
                step_rem = CNT_W'(t - {1'b0, cnt_reg});
            else
                step_rem = t[CNT_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        hash_next    = hash_reg;
        rem_next     = rem_reg;
        verdict_next = verdict_reg;
        rew_next     = rew_reg;
        port_next    = port_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    hash_next    = job.hash;
                    rem_next     = '0;
                    iter_next    = 4'd0;
                    verdict_next = job.verdict;
                    rew_next     = 1'b0;
                    port_next    = 16'd0;
                    state_next   = job.do_mod ? S_MOD : S_HOLD;
                end
            end
            S_MOD:
            begin
                hash_next = step_hash;
                rem_next  = step_rem;
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'd15)
                begin
                    rew_next   = 1'b1;
                    port_next  = ports_reg[step_rem[KW-1:0]];
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        iter_reg    <= iter_next;
        hash_reg    <= hash_next;
        rem_reg     <= rem_next;
        verdict_reg <= verdict_next;
        rew_reg     <= rew_next;
        port_reg    <= port_next;
        if (state_reg == S_IDLE && job_valid)
        begin
            cnt_reg   <= job.cnt;
            ports_reg <= job_ports;
        end
    end

endmodule
`default_nettype wire

// File: rtl/udp_port_shard_steer.sv
// UDP port shard steering block, top level
//
// Input stream carries one word per frame byte or per shard table write
// (s_axis_tuser selects which); s_axis_tlast marks a frame's last byte.
// Each frame gives exactly one output word at its last byte: the verdict,
// whether the destination port was rewritten and the chosen shard port.
// Table writes give no output and take effect at once, also mid-frame.
// The front part takes one input word per cycle while its two-entry queue
// has room. The back part works one frame at a time: a frame that needs
// a shard pick is reduced in the modulo unit at 4 hash bits per cycle
// over the 64-bit FNV-1a hash before its result appears; other verdicts
// go straight to the output register. A new frame is taken from the queue
// only after the previous frame's output word has been taken by the receiver.
// A stalled output holds its word; the queue then fills and s_axis_tready
// drops until the receiver takes the word.
// Reset clears the frame state, the hash to its offset basis and the whole
// shard table.
`default_nettype none
module udp_port_shard_steer #(
    parameter int MAX_SHARDS  = 8,
    parameter int TABLE_SLOTS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // frame_byte[7:0], table_slot[9:8], table_word[14:10], table_value[30:15]
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    // opcode[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // verdict[0], rewritten[1], new_port[17:2]
    output logic [23:0]      m_axis_tdata
);
    import usps_pkg::*;

    localparam int PW = MAX_SHARDS * 16;
    localparam int QW = $bits(job_t) + PW;

    logic                        fj_valid, fj_ready, bj_valid, bj_ready;
    job_t                        fjob, bjob;
    logic [MAX_SHARDS-1:0][15:0] fports, bports;
    logic [QW-1:0]               q_out;
    logic                        verdict, rewritten;
    logic [15:0]                 new_port;

    // byte parsing and table
    usps_front #(
        .MAX_SHARDS  (MAX_SHARDS),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (opcode_t'(s_axis_tuser)),
        .in_last   (s_axis_tlast),
        .in_byte   (s_axis_tdata[7:0]),
        .in_slot   (s_axis_tdata[9:8]),
        .in_word   (s_axis_tdata[14:10]),
        .in_value  (s_axis_tdata[30:15]),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job       (fjob),
        .job_ports (fports)
    );

    // queue between the parts
    usps_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fj_valid),
        .in_ready  (fj_ready),
        .in_data   ({fjob, fports}),
        .out_valid (bj_valid),
        .out_ready (bj_ready),
        .out_data  (q_out)
    );

    assign bjob   = q_out[QW-1:PW];
    assign bports = q_out[PW-1:0];

    // modulo and port pick
    usps_back #(
        .MAX_SHARDS (MAX_SHARDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bjob),
        .job_ports (bports),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .verdict   (verdict),
        .rewritten (rewritten),
        .new_port  (new_port)
    );

    assign m_axis_tdata = {6'd0, new_port, rewritten, verdict};

endmodule
`default_nettype wire
